### design/assert_macros.svh
// Assertion helpers, included by otbg_emit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define OTBG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define OTBG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/otbg_pkg.sv
package otbg_pkg;

    localparam int MSG_MAX    = 9;
    localparam int FONT_WIDTH = 5;
    localparam int CNT_W      = $clog2(MSG_MAX + 1);

    localparam logic [7:0] FIRST_CHAR  = 8'd32;
    localparam logic [8:0] GLYPH_END   = 9'd129;
    localparam logic [8:0] FONT_W9     = 9'(FONT_WIDTH);
    localparam logic [7:0] FONT_W8     = 8'(FONT_WIDTH);
    localparam logic [6:0] HEIGHT_MAX  = 7'd64;

    localparam logic [7:0] CTRL_CMD    = 8'h00;
    localparam logic [7:0] CTRL_DATA   = 8'h40;
    localparam logic [7:0] COL_LOW     = 8'h00;
    localparam logic [7:0] COL_HIGH    = 8'h10;
    localparam logic [7:0] PAGE_ADDR   = 8'hB0;
    localparam logic [7:0] NIBBLE_MASK = 8'h0F;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_ROW  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_GLYPH = 2'd1;
    localparam logic [1:0] ST_EDGE     = 2'd2;
    localparam logic [1:0] ST_ROW      = 2'd3;

    localparam logic [1:0] CFG_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_OFFSET  = 2'd2;
    localparam logic [1:0] CFG_SPACING = 2'd3;

    localparam logic [7:0] RST_WIDTH   = 8'd128;
    localparam logic [6:0] RST_HEIGHT  = 7'd64;
    localparam logic [2:0] RST_OFFSET  = 3'd0;
    localparam logic [1:0] RST_SPACING = 2'd1;

    typedef struct packed {
        logic [MSG_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]        count;
        logic                    byte_valid;
        logic [1:0]              status;
    } t_msg;

    // Five glyph columns, leftmost column in the top byte.
    function automatic logic [FONT_WIDTH*8-1:0] glyph_cols(input logic [6:0] g);
        logic [FONT_WIDTH*8-1:0] c;
        case (g)
            7'd0:  c = 40'h0000000000;
            7'd1:  c = 40'h00005F0000;
            7'd2:  c = 40'h0007000700;
            7'd3:  c = 40'h147F147F14;
            7'd4:  c = 40'h242A7F2A12;
            7'd5:  c = 40'h2313086462;
            7'd6:  c = 40'h3649552250;
            7'd7:  c = 40'h0005030000;
            7'd8:  c = 40'h001C224100;
            7'd9:  c = 40'h0041221C00;
            7'd10: c = 40'h082A1C2A08;
            7'd11: c = 40'h08083E0808;
            7'd12: c = 40'h0050300000;
            7'd13: c = 40'h0808080808;
            7'd14: c = 40'h0060600000;
            7'd15: c = 40'h2010080402;
            7'd16: c = 40'h3E5149453E;
            7'd17: c = 40'h00427F4000;
            7'd18: c = 40'h4261514946;
            7'd19: c = 40'h2141454B31;
            7'd20: c = 40'h1814127F10;
            7'd21: c = 40'h2745454539;
            7'd22: c = 40'h3C4A494930;
            7'd23: c = 40'h0171090503;
            7'd24: c = 40'h3649494936;
            7'd25: c = 40'h064949291E;
            7'd26: c = 40'h0036360000;
            7'd27: c = 40'h0056360000;
            7'd28: c = 40'h0008142241;
            7'd29: c = 40'h1414141414;
            7'd30: c = 40'h4122140800;
            7'd31: c = 40'h0201510906;
            7'd32: c = 40'h324979413E;
            7'd33: c = 40'h7E1111117E;
            7'd34: c = 40'h7F49494936;
            7'd35: c = 40'h3E41414122;
            7'd36: c = 40'h7F4141221C;
            7'd37: c = 40'h7F49494941;
            7'd38: c = 40'h7F09090101;
            7'd39: c = 40'h3E41415132;
            7'd40: c = 40'h7F0808087F;
            7'd41: c = 40'h00417F4100;
            7'd42: c = 40'h2040413F01;
            7'd43: c = 40'h7F08142241;
            7'd44: c = 40'h7F40404040;
            7'd45: c = 40'h7F0204027F;
            7'd46: c = 40'h7F0408107F;
            7'd47: c = 40'h3E4141413E;
            7'd48: c = 40'h7F09090906;
            7'd49: c = 40'h3E4151215E;
            7'd50: c = 40'h7F09192946;
            7'd51: c = 40'h4649494931;
            7'd52: c = 40'h01017F0101;
            7'd53: c = 40'h3F4040403F;
            7'd54: c = 40'h1F2040201F;
            7'd55: c = 40'h7F2018207F;
            7'd56: c = 40'h6314081463;
            7'd57: c = 40'h0304780403;
            7'd58: c = 40'h6151494543;
            7'd59: c = 40'h00007F4141;
            7'd60: c = 40'h0204081020;
            7'd61: c = 40'h41417F0000;
            7'd62: c = 40'h0402010204;
            7'd63: c = 40'h4040404040;
            7'd64: c = 40'h0001020400;
            7'd65: c = 40'h2054545478;
            7'd66: c = 40'h7F48444438;
            7'd67: c = 40'h3844444420;
            7'd68: c = 40'h384444487F;
            7'd69: c = 40'h3854545418;
            7'd70: c = 40'h087E090102;
            7'd71: c = 40'h081454543C;
            7'd72: c = 40'h7F08040478;
            7'd73: c = 40'h00447D4000;
            7'd74: c = 40'h2040443D00;
            7'd75: c = 40'h007F102844;
            7'd76: c = 40'h00417F4000;
            7'd77: c = 40'h7C04180478;
            7'd78: c = 40'h7C08040478;
            7'd79: c = 40'h3844444438;
            7'd80: c = 40'h7C14141408;
            7'd81: c = 40'h081414187C;
            7'd82: c = 40'h7C08040408;
            7'd83: c = 40'h4854545420;
            7'd84: c = 40'h043F444020;
            7'd85: c = 40'h3C4040207C;
            7'd86: c = 40'h1C2040201C;
            7'd87: c = 40'h3C4030403C;
            7'd88: c = 40'h4428102844;
            7'd89: c = 40'h0C5050503C;
            7'd90: c = 40'h4464544C44;
            7'd91: c = 40'h0008364100;
            7'd92: c = 40'h00007F0000;
            7'd93: c = 40'h0041360800;
            7'd94: c = 40'h08082A1C08;
            7'd95: c = 40'h081C2A0808;
            7'd96: c = 40'h0006090906;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

### design/otbg_in_if.sv
interface otbg_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] char_code;
    logic [4:0] text_line;

    modport source (output valid, output opcode, output char_code, output text_line,
                    input ready);
    modport sink   (input valid, input opcode, input char_code, input text_line,
                    output ready);
endinterface

### design/otbg_out_if.sv
interface otbg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       last_of_message;

    modport source (output valid, output out_byte, output byte_valid, output status,
                    output last_of_message, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input status,
                    input last_of_message, output ready);
endinterface

### design/otbg_cmd.sv
module otbg_cmd (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [7:0]       i_cfg_data,
    otbg_in_if.sink          i_req,
    input  logic             i_take,
    output logic             o_msg_valid,
    output otbg_pkg::t_msg   o_msg
);

    logic       r_in_valid;
    logic       r_opcode;
    logic [7:0] r_char;
    logic [4:0] r_line;

    logic [7:0] r_width;
    logic [6:0] r_height;
    logic [2:0] r_offset;
    logic [1:0] r_spacing;
    logic [7:0] r_col;
    logic [7:0] n_col;

    logic [7:0] row;
    logic [6:0] height;
    logic [7:0] ch_off;
    logic [7:0] offset_col;
    logic [otbg_pkg::FONT_WIDTH*8-1:0] cols;
    otbg_pkg::t_msg msg;

    assign i_req.ready = !r_in_valid || i_take;
    assign o_msg_valid = r_in_valid;
    assign o_msg       = msg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (i_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_opcode <= i_req.opcode;
            r_char   <= i_req.char_code;
            r_line   <= i_req.text_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= otbg_pkg::RST_WIDTH;
            r_height  <= otbg_pkg::RST_HEIGHT;
            r_offset  <= otbg_pkg::RST_OFFSET;
            r_spacing <= otbg_pkg::RST_SPACING;
            r_col     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    otbg_pkg::CFG_WIDTH:   r_width   <= i_cfg_data;
                    otbg_pkg::CFG_HEIGHT:  r_height  <= i_cfg_data[6:0];
                    otbg_pkg::CFG_OFFSET:  r_offset  <= i_cfg_data[2:0];
                    otbg_pkg::CFG_SPACING: r_spacing <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_take) begin
                r_col <= n_col;
            end
        end
    end

    assign row        = {r_line, 3'b000};
    assign height     = (r_height > otbg_pkg::HEIGHT_MAX) ? otbg_pkg::HEIGHT_MAX : r_height;
    assign ch_off     = r_char - otbg_pkg::FIRST_CHAR;
    assign offset_col = {5'b00000, r_offset};
    assign cols       = otbg_pkg::glyph_cols(ch_off[6:0]);

    always_comb begin
        msg            = '0;
        msg.byte_valid = 1'b1;
        msg.status     = otbg_pkg::ST_OK;
        n_col          = r_col;
        case (r_opcode)
            otbg_pkg::OP_ROW: begin
                if (row >= {1'b0, height}) begin
                    msg.byte_valid = 1'b0;
                    msg.status     = otbg_pkg::ST_ROW;
                    msg.count      = otbg_pkg::CNT_W'(1);
                end else begin
                    msg.bytes[0] = otbg_pkg::CTRL_CMD;
                    msg.bytes[1] = otbg_pkg::COL_LOW | (offset_col & otbg_pkg::NIBBLE_MASK);
                    msg.bytes[2] = otbg_pkg::COL_HIGH | {4'h0, offset_col[7:4]};
                    msg.bytes[3] = otbg_pkg::PAGE_ADDR | {5'b00000, r_line[2:0]};
                    msg.count    = otbg_pkg::CNT_W'(4);
                    n_col        = offset_col;
                end
            end
            otbg_pkg::OP_CHAR: begin
                if (r_char < otbg_pkg::FIRST_CHAR || {1'b0, r_char} >= otbg_pkg::GLYPH_END) begin
                    msg.byte_valid = 1'b0;
                    msg.status     = otbg_pkg::ST_NO_GLYPH;
                    msg.count      = otbg_pkg::CNT_W'(1);
                end else if ({1'b0, r_col} + otbg_pkg::FONT_W9 > {1'b0, r_width}) begin
                    msg.byte_valid = 1'b0;
                    msg.status     = otbg_pkg::ST_EDGE;
                    msg.count      = otbg_pkg::CNT_W'(1);
                end else begin
                    msg.bytes[0] = otbg_pkg::CTRL_DATA;
                    for (int i = 0; i < otbg_pkg::FONT_WIDTH; i++) begin
                        msg.bytes[i+1] = cols[(otbg_pkg::FONT_WIDTH-1-i)*8 +: 8];
                    end
                    msg.count = otbg_pkg::CNT_W'(otbg_pkg::FONT_WIDTH + 1)
                              + {{(otbg_pkg::CNT_W-2){1'b0}}, r_spacing};
                    n_col     = r_col + otbg_pkg::FONT_W8 + {6'b000000, r_spacing};
                end
            end
            default: ;
        endcase
    end

endmodule

### design/otbg_emit.sv
`include "assert_macros.svh"

module otbg_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_msg_valid,
    input  otbg_pkg::t_msg   i_msg,
    output logic             o_take,
    otbg_out_if.source       o_res
);

    logic [otbg_pkg::MSG_MAX-1:0][7:0] r_bytes;
    logic [otbg_pkg::CNT_W-1:0]        r_left;
    logic                              r_bvalid;
    logic [1:0]                        r_status;
    logic                              fire;
    logic                              is_last;

    assign is_last = (r_left == otbg_pkg::CNT_W'(1));
    assign fire    = o_res.valid && o_res.ready;
    assign o_take  = i_msg_valid && ((r_left == '0) || (is_last && o_res.ready));

    assign o_res.valid           = (r_left != '0);
    assign o_res.out_byte        = r_bytes[0];
    assign o_res.byte_valid      = r_bvalid;
    assign o_res.status          = r_status;
    assign o_res.last_of_message = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (o_take) begin
            r_left <= i_msg.count;
        end else if (fire) begin
            r_left <= r_left - otbg_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_bytes  <= i_msg.bytes;
            r_bvalid <= i_msg.byte_valid;
            r_status <= i_msg.status;
        end else if (fire) begin
            r_bytes  <= r_bytes >> 8;
        end
    end

    `OTBG_ASSERT(a_take_shows, o_take |=> o_res.valid, "loaded request shows no result")
    `OTBG_ASSERT(a_msg_unbroken, fire && !is_last |=> o_res.valid, "message broken off early")
    `OTBG_ASSERT_ALWAYS(a_reject_single, o_res.valid && !r_bvalid |-> is_last && r_status != otbg_pkg::ST_OK, "rejection is not a single result")

endmodule

### design/oled_text_byte_generator.sv
// A request is held in the input register and its message is then loaded into the output
// shift register, which gives one result byte per cycle while the receiver is ready. A request
// gives one byte if rejected, four for a row change and six plus letter spacing for a glyph.
// A request waits in the input register while the previous message drains.
// Reset (synchronous, active low) empties both stages, clears the cursor to column zero and
// restores width 128, height 64, column offset 0 and letter spacing 1.
module oled_text_byte_generator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    otbg_in_if.sink    i_req,
    otbg_out_if.source o_res
);

    logic           msg_valid;
    logic           take;
    otbg_pkg::t_msg msg;

    otbg_cmd u_cmd (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .i_take      (take),
        .o_msg_valid (msg_valid),
        .o_msg       (msg)
    );

    otbg_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_msg_valid (msg_valid),
        .i_msg       (msg),
        .o_take      (take),
        .o_res       (o_res)
    );

endmodule

### tb/oled_text_byte_generator_test.sv
`timescale 1ns / 100ps

module oled_text_byte_generator_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ROM_BYTES   = 485;
    localparam int FONT_GLYPHS = 97;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic [1:0] status;
        logic       last;
    } t_oled_byte;

    class oled_message_model;
        logic [39:0] font_cols [0:FONT_GLYPHS-1];
        t_oled_byte  awaited_bytes [$];
        int width;
        int height;
        int offset;
        int spacing;
        int column;
        int pixel_row;
        int errors;
        int requests;
        int checked;
        int rows_moved;
        int glyphs_drawn;
        int wraps;
        int rejected [4];

        function new();
            font_cols = '{
                40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
                40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
                40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
                40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
                40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
                40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
                40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
                40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
                40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
                40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
                40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
                40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
                40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
                40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
                40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
                40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
                40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
                40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
                40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
                40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
                40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
                40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
                40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
                40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808,
                40'h0006090906
            };
            width = int'(otbg_pkg::RST_WIDTH);
            height = int'(otbg_pkg::RST_HEIGHT);
            offset = int'(otbg_pkg::RST_OFFSET);
            spacing = int'(otbg_pkg::RST_SPACING);
            column = 0;
            pixel_row = 0;
        endfunction

        function void set_config(int w, int h, int o, int s);
            width = w;
            height = h;
            offset = o;
            spacing = s;
        endfunction

        function int pending();
            return awaited_bytes.size();
        endfunction

        function int failures();
            return errors + awaited_bytes.size();
        endfunction

        function void note_request(logic op, logic [7:0] ch, logic [4:0] line);
            logic [7:0] msg [$];
            logic [1:0] verdict;
            t_oled_byte entry;
            int         limit_h;
            int         row;
            int         idx;
            int         total;
            int         i;
            requests++;
            verdict = otbg_pkg::ST_OK;
            if (op == otbg_pkg::OP_ROW) begin
                row = int'(line) * 8;
                limit_h = (height > int'(otbg_pkg::HEIGHT_MAX)) ?
                          int'(otbg_pkg::HEIGHT_MAX) : height;
                if (row >= limit_h) begin
                    verdict = otbg_pkg::ST_ROW;
                end else begin
                    pixel_row = row;
                    column = offset;
                    rows_moved++;
                    msg.push_back(otbg_pkg::CTRL_CMD);
                    msg.push_back(otbg_pkg::COL_LOW | (8'(column) & otbg_pkg::NIBBLE_MASK));
                    msg.push_back(otbg_pkg::COL_HIGH | 8'(column >> 4));
                    msg.push_back(otbg_pkg::PAGE_ADDR | 8'(pixel_row >> 3));
                end
            end else if (ch < otbg_pkg::FIRST_CHAR || {1'b0, ch} >= otbg_pkg::GLYPH_END) begin
                verdict = otbg_pkg::ST_NO_GLYPH;
            end else if (column + otbg_pkg::FONT_WIDTH > width) begin
                verdict = otbg_pkg::ST_EDGE;
            end else begin
                msg.push_back(otbg_pkg::CTRL_DATA);
                for (i = 0; i < otbg_pkg::FONT_WIDTH && msg.size() < otbg_pkg::MSG_MAX;
                     i++) begin
                    idx = (int'(ch) - int'(otbg_pkg::FIRST_CHAR)) * otbg_pkg::FONT_WIDTH + i;
                    if (idx < ROM_BYTES)
                        msg.push_back(font_cols[idx / 5][8 * (4 - idx % 5) +: 8]);
                    else
                        msg.push_back(8'h00);
                end
                for (i = 0; i < spacing && msg.size() < otbg_pkg::MSG_MAX; i++)
                    msg.push_back(8'h00);
                total = column + otbg_pkg::FONT_WIDTH + spacing;
                if (total > 255)
                    wraps++;
                column = total % 256;
                glyphs_drawn++;
            end
            if (verdict != otbg_pkg::ST_OK) begin
                rejected[verdict]++;
                msg.push_back(8'h00);
            end
            foreach (msg[k]) begin
                entry.data = msg[k];
                entry.valid = (verdict == otbg_pkg::ST_OK);
                entry.status = verdict;
                entry.last = (k == msg.size() - 1);
                awaited_bytes.push_back(entry);
            end
        endfunction

        function void check_byte(logic [7:0] data, logic valid, logic [1:0] status,
                                 logic last);
            t_oled_byte got;
            t_oled_byte want;
            got.data = data;
            got.valid = valid;
            got.status = status;
            got.last = last;
            checked++;
            if (awaited_bytes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result: byte %02h valid %0d status %0d last %0d",
                             data, valid, status, last);
                return;
            end
            want = awaited_bytes.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display({"Mismatch: expected byte %02h valid %0d status %0d last %0d,",
                              " got byte %02h valid %0d status %0d last %0d"},
                             want.data, want.valid, want.status, want.last,
                             data, valid, status, last);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;
    bit         calm;
    int         cur_height;
    int         cycle_count;
    oled_message_model model;

    otbg_in_if  req_if ();
    otbg_out_if res_if ();

    oled_text_byte_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with requests still in flight.", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        res_if.ready <= calm || ($urandom_range(99) >= 30);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready)
                model.check_byte(res_if.out_byte, res_if.byte_valid, res_if.status,
                                 res_if.last_of_message);
            if (req_if.valid && req_if.ready)
                model.note_request(req_if.opcode, req_if.char_code, req_if.text_line);
        end
    end

    task automatic send_request(input logic op, input logic [7:0] ch, input logic [4:0] line);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 30) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.opcode <= op;
        req_if.char_code <= ch;
        req_if.text_line <= line;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
    endtask

    task automatic wait_drained();
        @(negedge i_clk) req_if.valid <= 1'b0;
        while (model.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= 8'(val);
    endtask

    task automatic configure(input int w, input int h, input int o, input int s);
        wait_drained();
        cfg_write(otbg_pkg::CFG_WIDTH, w);
        cfg_write(otbg_pkg::CFG_HEIGHT, h);
        cfg_write(otbg_pkg::CFG_OFFSET, o);
        cfg_write(otbg_pkg::CFG_SPACING, s);
        @(negedge i_clk) i_cfg_we <= 1'b0;
        model.set_config(w, h, o, s);
        cur_height = h;
    endtask

    function automatic logic [7:0] pick_char();
        if ($urandom_range(99) < 90)
            return 8'($urandom_range(128, 32));
        if ($urandom_range(1) == 0)
            return 8'($urandom_range(31, 0));
        return 8'($urandom_range(255, 129));
    endfunction

    // Mostly a row change followed by a run of characters, with some stray requests mixed in.
    task automatic run_text(input int count);
        int sent;
        int last_pause;
        int rows;
        int burst;
        int k;
        sent = 0;
        last_pause = 0;
        while (sent < count) begin
            rows = ((cur_height > int'(otbg_pkg::HEIGHT_MAX)) ?
                    int'(otbg_pkg::HEIGHT_MAX) : cur_height) / 8;
            if ($urandom_range(99) < 85) begin
                send_request(otbg_pkg::OP_ROW, 8'($urandom), 5'($urandom_range(rows - 1, 0)));
                burst = $urandom_range(24, 1);
                if (burst > count - sent - 1)
                    burst = count - sent - 1;
                for (k = 0; k < burst; k++)
                    send_request(otbg_pkg::OP_CHAR, pick_char(), 5'($urandom));
                sent += burst + 1;
            end else begin
                send_request(1'($urandom), 8'($urandom), 5'($urandom));
                sent++;
            end
            if (sent - last_pause >= 40) begin
                wait_drained();
                last_pause = sent;
            end
        end
    endtask

    initial begin
        model = new();
        calm = 1'b0;
        cur_height = int'(otbg_pkg::RST_HEIGHT);
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = otbg_pkg::CFG_WIDTH;
        i_cfg_data = 8'h00;
        req_if.valid = 1'b0;
        req_if.opcode = otbg_pkg::OP_CHAR;
        req_if.char_code = 8'h00;
        req_if.text_line = 5'd0;
        res_if.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        send_request(otbg_pkg::OP_ROW, 8'h00, 5'd0);
        send_request(otbg_pkg::OP_ROW, 8'hFF, 5'd7);
        send_request(otbg_pkg::OP_ROW, 8'h41, 5'd8);
        send_request(otbg_pkg::OP_ROW, 8'h20, 5'd31);
        send_request(otbg_pkg::OP_CHAR, 8'd32, 5'd31);
        send_request(otbg_pkg::OP_CHAR, 8'd128, 5'd0);
        send_request(otbg_pkg::OP_CHAR, 8'd31, 5'd0);
        send_request(otbg_pkg::OP_CHAR, 8'd129, 5'd0);
        send_request(otbg_pkg::OP_CHAR, 8'd0, 5'd0);
        send_request(otbg_pkg::OP_CHAR, 8'd255, 5'd31);
        send_request(otbg_pkg::OP_CHAR, 8'd65, 5'd0);
        send_request(otbg_pkg::OP_CHAR, 8'd126, 5'd0);

        // A narrow display: the fourth character runs past the right edge.
        configure(20, int'(otbg_pkg::RST_HEIGHT), 0, 1);
        send_request(otbg_pkg::OP_ROW, 8'h00, 5'd1);
        send_request(otbg_pkg::OP_CHAR, 8'd72, 5'd0);
        send_request(otbg_pkg::OP_CHAR, 8'd105, 5'd0);
        send_request(otbg_pkg::OP_CHAR, 8'd33, 5'd0);
        send_request(otbg_pkg::OP_CHAR, 8'd120, 5'd0);
        send_request(otbg_pkg::OP_CHAR, 8'd200, 5'd0);
        send_request(otbg_pkg::OP_ROW, 8'h00, 5'd2);
        send_request(otbg_pkg::OP_CHAR, 8'd79, 5'd0);

        // Full width with the widest spacing: the cursor column wraps past 255.
        calm = 1'b1;
        configure(255, 64, 0, 3);
        send_request(otbg_pkg::OP_ROW, 8'h00, 5'd3);
        repeat (36) send_request(otbg_pkg::OP_CHAR, 8'($urandom_range(128, 32)), 5'($urandom));
        calm = 1'b0;

        configure(int'(otbg_pkg::RST_WIDTH), int'(otbg_pkg::RST_HEIGHT),
                  int'(otbg_pkg::RST_OFFSET), int'(otbg_pkg::RST_SPACING));
        run_text(60);
        configure(8, 8, 7, 0);
        run_text(16);
        configure(132, 127, 2, 2);
        run_text(60);
        configure(96, 32, 5, 0);
        run_text(45);
        repeat (3) begin
            configure($urandom_range(255, 8), $urandom_range(127, 8), $urandom_range(7, 0),
                      $urandom_range(3, 0));
            run_text(25);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d requests and %0d result bytes: %0d row moves, %0d glyphs, %0d wraps.",
                 model.requests, model.checked, model.rows_moved, model.glyphs_drawn,
                 model.wraps);
        $display("Rejected: %0d outside the font, %0d past the right edge, %0d below the screen.",
                 model.rejected[otbg_pkg::ST_NO_GLYPH], model.rejected[otbg_pkg::ST_EDGE],
                 model.rejected[otbg_pkg::ST_ROW]);
        if (model.failures() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
